// ----- design/bhvc_pkg.sv -----
package bhvc_pkg;

  localparam int CFG_ADDR_W = 5;

  localparam logic [10:0] VOLT_CEIL = 11'd1300;

  localparam logic [31:0]        MAINTAIN_RST    = 32'd60000;
  localparam logic [31:0]        HOLDOFF_RST     = 32'd120000;
  localparam logic [10:0]        VOLT_MAX_RST    = 11'd1150;
  localparam logic [10:0]        VOLT_MIN_RST    = 11'd100;
  localparam logic [10:0]        VOLT_KNEE_RST   = 11'd760;
  localparam logic [10:0]        START_VOLT_RST  = 11'd540;
  localparam logic signed [15:0] START_DELTA_RST = 16'sd160;

  localparam logic [5:0] BAND_STEPS  [4] = '{6'd15, 6'd25, 6'd35, 6'd60};
  localparam logic [6:0] BAND_TENTHS [4] = '{7'd20, 7'd40, 7'd60, 7'd100};
  localparam logic [6:0] BAND_KNEE   [4] = '{7'd14, 7'd28, 7'd42, 7'd70};

  typedef enum logic [1:0] {
    CMD_SENSOR    = 2'd0,
    CMD_BUTTON    = 2'd1,
    CMD_SET_DELTA = 2'd2,
    CMD_SET_VOLT  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_NONE          = 3'd0,
    ST_IN_BAND       = 3'd1,
    ST_RAISED        = 3'd2,
    ST_LOWERED       = 3'd3,
    ST_RAISE_REFUSED = 3'd4,
    ST_LOWER_REFUSED = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    REG_MAINTAIN    = 3'd0,
    REG_HOLDOFF     = 3'd1,
    REG_VOLT_MAX    = 3'd2,
    REG_VOLT_MIN    = 3'd3,
    REG_VOLT_KNEE   = 3'd4,
    REG_START_VOLT  = 3'd5,
    REG_START_DELTA = 3'd6
  } reg_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [31:0]        now_ms;
    logic signed [15:0] probe_a;
    logic signed [15:0] probe_b;
    logic signed [15:0] probe_c;
    logic signed [15:0] probe_d;
    logic signed [15:0] ambient_temp;
    logic [9:0]         button_level;
    logic signed [15:0] set_value;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [5:0]         step_count;
    logic               step_dir;
    logic [10:0]        voltage_tenths;
    logic signed [15:0] delta_out;
    logic signed [15:0] target_temp;
    logic signed [15:0] box_average;
    logic signed [15:0] ambient_mean;
  } out_item_t;

  typedef struct packed {
    logic [31:0]        maintain_ms;
    logic [31:0]        holdoff_ms;
    logic [10:0]        volt_max;
    logic [10:0]        volt_min;
    logic [10:0]        volt_knee;
    logic               volt_ld;
    logic [10:0]        volt_val;
    logic               delta_ld;
    logic signed [15:0] delta_val;
  } cfg_t;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -17'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- design/bhvc_if.sv -----
interface bhvc_in_if;
  import bhvc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bhvc_out_if;
  import bhvc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/bhvc_cfg.sv -----
module bhvc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bhvc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  output bhvc_pkg::cfg_t                  cfg_o
);
  import bhvc_pkg::*;

  logic [31:0]        maintain_q;
  logic [31:0]        holdoff_q;
  logic [10:0]        volt_max_q;
  logic [10:0]        volt_min_q;
  logic [10:0]        volt_knee_q;
  logic [10:0]        start_volt_q;
  logic signed [15:0] start_delta_q;
  logic               wr_en;
  logic [2:0]         wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = paddr[4:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maintain_q    <= MAINTAIN_RST;
      holdoff_q     <= HOLDOFF_RST;
      volt_max_q    <= VOLT_MAX_RST;
      volt_min_q    <= VOLT_MIN_RST;
      volt_knee_q   <= VOLT_KNEE_RST;
      start_volt_q  <= START_VOLT_RST;
      start_delta_q <= START_DELTA_RST;
    end else if (wr_en) begin
      unique case (wr_idx)
        REG_MAINTAIN:    maintain_q    <= pwdata;
        REG_HOLDOFF:     holdoff_q     <= pwdata;
        REG_VOLT_MAX:    volt_max_q    <= pwdata[10:0];
        REG_VOLT_MIN:    volt_min_q    <= pwdata[10:0];
        REG_VOLT_KNEE:   volt_knee_q   <= pwdata[10:0];
        REG_START_VOLT:  start_volt_q  <= pwdata[10:0];
        REG_START_DELTA: start_delta_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (wr_idx)
      REG_MAINTAIN:    prdata = maintain_q;
      REG_HOLDOFF:     prdata = holdoff_q;
      REG_VOLT_MAX:    prdata = 32'(volt_max_q);
      REG_VOLT_MIN:    prdata = 32'(volt_min_q);
      REG_VOLT_KNEE:   prdata = 32'(volt_knee_q);
      REG_START_VOLT:  prdata = 32'(start_volt_q);
      REG_START_DELTA: prdata = 32'(start_delta_q);
      default:         prdata = 32'd0;
    endcase
  end

  always_comb begin
    cfg_o.maintain_ms = maintain_q;
    cfg_o.holdoff_ms  = holdoff_q;
    cfg_o.volt_max    = volt_max_q;
    cfg_o.volt_min    = volt_min_q;
    cfg_o.volt_knee   = volt_knee_q;
    cfg_o.volt_ld     = wr_en && (wr_idx == REG_START_VOLT);
    cfg_o.volt_val    = pwdata[10:0];
    cfg_o.delta_ld    = wr_en && (wr_idx == REG_START_DELTA);
    cfg_o.delta_val   = pwdata[15:0];
  end

endmodule

// ----- design/banded_heater_voltage_controller.sv -----
// Banded deadband heater voltage controller. Each item (sensor update, button sample,
// set delta, set voltage) yields exactly one result item. An accepted item is held in an
// input register, goes through combinational evaluation logic (probe and window sums,
// exact error compare against four bands, voltage step with limits and knee scaling)
// and lands in a result register. One item is taken every cycle while the result side
// keeps up; the combinational evaluation path between the two registers sets that rate.
// The ambient and button windows are shift registers of AMBIENT_WINDOW-1 and
// BUTTON_WINDOW-1 samples with fill counts. Configuration goes through the APB port at
// byte address 4*index; writing the start voltage or start delta also loads the live
// value. Write it only while no item is in flight.
module banded_heater_voltage_controller #(
  parameter int AMBIENT_WINDOW = 5,
  parameter int BUTTON_WINDOW  = 5
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bhvc_in_if.sink                         in_i,
  bhvc_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bhvc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import bhvc_pkg::*;

  localparam int ADEPTH  = AMBIENT_WINDOW - 1;
  localparam int AFILL_W = $clog2(AMBIENT_WINDOW);
  localparam int ASUM_W  = 16 + $clog2(AMBIENT_WINDOW);
  localparam int E_W     = 21 + $clog2(AMBIENT_WINDOW);
  localparam int MEAN_SH = ASUM_W + $clog2(AMBIENT_WINDOW);
  localparam int MUL_W   = MEAN_SH + 1;
  localparam int P_W     = ASUM_W + MUL_W;
  localparam longint MEAN_MUL =
    ((longint'(1) << MEAN_SH) + longint'(AMBIENT_WINDOW) - 1) / longint'(AMBIENT_WINDOW);
  localparam int BDEPTH  = BUTTON_WINDOW - 1;
  localparam int BFILL_W = $clog2(BUTTON_WINDOW);
  localparam int BSUM_W  = 10 + $clog2(BUTTON_WINDOW);

  localparam logic signed [E_W-1:0] W_E  = E_W'(AMBIENT_WINDOW);
  localparam logic signed [E_W-1:0] W4_E = E_W'(4 * AMBIENT_WINDOW);
  localparam logic [E_W-1:0] THR_BAND = E_W'(32 * AMBIENT_WINDOW);
  localparam logic [E_W-1:0] THR1     = E_W'(64 * AMBIENT_WINDOW);
  localparam logic [E_W-1:0] THR2     = E_W'(128 * AMBIENT_WINDOW);
  localparam logic [E_W-1:0] THR3     = E_W'(192 * AMBIENT_WINDOW);
  localparam logic [P_W-1:0] MUL_P    = P_W'(MEAN_MUL);
  localparam logic [BSUM_W-1:0] BTN_UP_LO = BSUM_W'(10 * BUTTON_WINDOW);
  localparam logic [BSUM_W-1:0] BTN_UP_HI = BSUM_W'(14 * BUTTON_WINDOW);
  localparam logic [BSUM_W-1:0] BTN_DN_LO = BSUM_W'(18 * BUTTON_WINDOW);
  localparam logic [BSUM_W-1:0] BTN_DN_HI = BSUM_W'(23 * BUTTON_WINDOW);

  cfg_t cfg;

  bhvc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  logic      in_valid_q;
  in_item_t  in_q;
  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res_d;
  logic      adv;
  logic      fire;

  logic signed [15:0] delta_q, delta_d;
  logic [10:0]        volt_q, volt_d;
  logic signed [15:0] amb_mean_q, amb_mean_d;
  logic [31:0]        last_eval_q, last_eval_d;
  logic [31:0]        last_change_q, last_change_d;
  logic signed [15:0] last_avg_q, last_avg_d;
  logic signed [15:0] last_tgt_q, last_tgt_d;
  logic [AFILL_W-1:0] amb_fill_q, amb_fill_d;
  logic [BFILL_W-1:0] btn_fill_q, btn_fill_d;
  logic signed [15:0] amb_win_q [ADEPTH];
  logic [9:0]         btn_win_q [BDEPTH];
  logic               amb_shift;
  logic               btn_shift;

  logic signed [17:0]       sum4;
  logic signed [ASUM_W-1:0] amb_sum;
  logic [ASUM_W-1:0]        amb_mag;
  logic [P_W-1:0]           mean_prod;
  logic [15:0]              mean_mag;
  logic signed [15:0]       amb_mean_new;
  logic signed [E_W-1:0]    err;
  logic [E_W-1:0]           err_mag;
  logic [1:0]               band;
  logic [6:0]               step;
  logic [11:0]              volt_up;
  logic                     time_ok;
  logic [BSUM_W-1:0]        btn_sum;
  logic                     btn_up;
  logic                     btn_dn;
  status_e                  res_status;
  logic [5:0]               res_steps;
  logic                     res_dir;

  assign adv         = !out_valid_q || out_o.ready;
  assign fire        = in_valid_q && adv;
  assign in_i.ready  = !in_valid_q || adv;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;
  assign amb_shift   = fire && (in_q.cmd == CMD_SENSOR);
  assign btn_shift   = fire && (in_q.cmd == CMD_BUTTON);

  always_comb begin
    sum4 = 18'(in_q.probe_a) + 18'(in_q.probe_b) + 18'(in_q.probe_c) + 18'(in_q.probe_d);
    amb_sum = ASUM_W'(in_q.ambient_temp);
    for (int i = 0; i < ADEPTH; i++) begin
      amb_sum = amb_sum + ASUM_W'(amb_win_q[i]);
    end
    btn_sum = BSUM_W'(in_q.button_level);
    for (int i = 0; i < BDEPTH; i++) begin
      btn_sum = btn_sum + BSUM_W'(btn_win_q[i]);
    end
  end

  always_comb begin
    amb_mag      = amb_sum[ASUM_W-1] ? ASUM_W'(-amb_sum) : ASUM_W'(amb_sum);
    mean_prod    = P_W'(amb_mag) * MUL_P;
    mean_mag     = mean_prod[MEAN_SH +: 16];
    amb_mean_new = amb_sum[ASUM_W-1] ? 16'(-mean_mag) : mean_mag;
  end

  always_comb begin
    err = E_W'(sum4) * W_E - E_W'(delta_q) * W4_E - (E_W'(amb_sum) <<< 2);
    err_mag = err[E_W-1] ? E_W'(-err) : E_W'(err);
    priority if (err_mag > THR3) begin
      band = 2'd3;
    end else if (err_mag > THR2) begin
      band = 2'd2;
    end else if (err_mag > THR1) begin
      band = 2'd1;
    end else begin
      band = 2'd0;
    end
    step    = (volt_q > cfg.volt_knee) ? BAND_KNEE[band] : BAND_TENTHS[band];
    volt_up = 12'(volt_q) + 12'(step);
    time_ok = ((in_q.now_ms - last_eval_q) >= cfg.maintain_ms) &&
              ((in_q.now_ms - last_change_q) >= cfg.holdoff_ms);
    btn_up  = (btn_sum > BTN_UP_LO) && (btn_sum < BTN_UP_HI);
    btn_dn  = (btn_sum > BTN_DN_LO) && (btn_sum < BTN_DN_HI);
  end

  always_comb begin
    delta_d       = delta_q;
    volt_d        = volt_q;
    amb_mean_d    = amb_mean_q;
    last_eval_d   = last_eval_q;
    last_change_d = last_change_q;
    last_avg_d    = last_avg_q;
    last_tgt_d    = last_tgt_q;
    amb_fill_d    = amb_fill_q;
    btn_fill_d    = btn_fill_q;
    res_status    = ST_NONE;
    res_steps     = 6'd0;
    res_dir       = 1'b0;
    if (fire) begin
      unique case (in_q.cmd)
        CMD_SENSOR: begin
          last_avg_d = 16'(sum4 / 18'sd4);
          last_tgt_d = sat16(17'(in_q.ambient_temp) + 17'(delta_q));
          if (amb_fill_q < AFILL_W'(ADEPTH)) begin
            amb_fill_d = AFILL_W'(amb_fill_q + 1'b1);
          end else if (time_ok) begin
            last_eval_d = in_q.now_ms;
            amb_mean_d  = amb_mean_new;
            if (err_mag <= THR_BAND) begin
              res_status = ST_IN_BAND;
            end else begin
              last_change_d = in_q.now_ms;
              if (err[E_W-1]) begin
                if (volt_q >= cfg.volt_max) begin
                  res_status = ST_RAISE_REFUSED;
                end else begin
                  res_status = ST_RAISED;
                  res_steps  = BAND_STEPS[band];
                  volt_d     = (volt_up > 12'(VOLT_CEIL)) ? VOLT_CEIL : volt_up[10:0];
                end
              end else begin
                if (volt_q <= cfg.volt_min) begin
                  res_status = ST_LOWER_REFUSED;
                end else begin
                  res_status = ST_LOWERED;
                  res_steps  = BAND_STEPS[band];
                  res_dir    = 1'b1;
                  volt_d     = (volt_q < 11'(step)) ? 11'd0 : volt_q - 11'(step);
                end
              end
            end
          end
        end
        CMD_BUTTON: begin
          if (btn_fill_q < BFILL_W'(BDEPTH)) begin
            btn_fill_d = BFILL_W'(btn_fill_q + 1'b1);
          end else if (btn_up) begin
            delta_d = sat16(17'(delta_q) + 17'sd16);
          end else if (btn_dn) begin
            delta_d = sat16(17'(delta_q) - 17'sd16);
          end
        end
        CMD_SET_DELTA: begin
          delta_d = in_q.set_value;
        end
        CMD_SET_VOLT: begin
          if (in_q.set_value[15]) begin
            volt_d = 11'd0;
          end else if (in_q.set_value > 16'sd1300) begin
            volt_d = VOLT_CEIL;
          end else begin
            volt_d = in_q.set_value[10:0];
          end
        end
        default: ;
      endcase
    end
    res_d.status         = res_status;
    res_d.step_count     = res_steps;
    res_d.step_dir       = res_dir;
    res_d.voltage_tenths = volt_d;
    res_d.delta_out      = delta_d;
    res_d.target_temp    = last_tgt_d;
    res_d.box_average    = last_avg_d;
    res_d.ambient_mean   = amb_mean_d;
    if (cfg.volt_ld) begin
      volt_d = (cfg.volt_val > VOLT_CEIL) ? VOLT_CEIL : cfg.volt_val;
    end
    if (cfg.delta_ld) begin
      delta_d = cfg.delta_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      delta_q       <= START_DELTA_RST;
      volt_q        <= START_VOLT_RST;
      amb_mean_q    <= 16'sd0;
      last_eval_q   <= 32'd0;
      last_change_q <= 32'd0;
      last_avg_q    <= 16'sd0;
      last_tgt_q    <= 16'sd0;
      amb_fill_q    <= '0;
      btn_fill_q    <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (adv) begin
        out_valid_q <= in_valid_q;
      end
      delta_q       <= delta_d;
      volt_q        <= volt_d;
      amb_mean_q    <= amb_mean_d;
      last_eval_q   <= last_eval_d;
      last_change_q <= last_change_d;
      last_avg_q    <= last_avg_d;
      last_tgt_q    <= last_tgt_d;
      amb_fill_q    <= amb_fill_d;
      btn_fill_q    <= btn_fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (fire) begin
      out_q <= res_d;
    end
    if (amb_shift) begin
      for (int i = 0; i < ADEPTH - 1; i++) begin
        amb_win_q[i] <= amb_win_q[i+1];
      end
      amb_win_q[ADEPTH-1] <= in_q.ambient_temp;
    end
    if (btn_shift) begin
      for (int i = 0; i < BDEPTH - 1; i++) begin
        btn_win_q[i] <= btn_win_q[i+1];
      end
      btn_win_q[BDEPTH-1] <= in_q.button_level;
    end
  end

endmodule

// ----- dv/tb_banded_heater_voltage_controller.sv -----
`timescale 1ns / 100ps

module tb_banded_heater_voltage_controller;
  import bhvc_pkg::*;

  typedef struct {
    in_item_t  item;
    bit        pinned;
    out_item_t want;
  } script_row_t;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [31:0]           pwdata  = '0;
  logic [31:0]           prdata;
  logic                  pready;

  bhvc_in_if  in_ch ();
  bhvc_out_if out_ch ();

  banded_heater_voltage_controller dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted controller state and its settings
  logic [31:0] cfg_maintain, cfg_holdoff;
  int          cfg_vmax, cfg_vmin, cfg_knee;
  int          amb_hist [4];
  int          btn_hist [4];
  int          amb_fill, btn_fill;
  int          delta_now, volt_now, mean_now, avg_now, target_now;
  logic [31:0] eval_ms, change_ms;

  out_item_t   due_results [$];
  script_row_t script [$];
  int          faults;
  bit          pin_flag;
  out_item_t   pin_want;
  bit          choke_req;
  logic [31:0] sim_ms;
  int          room;
  int          send_mood_left;
  bit          send_calm;

  always #5 clk_i = ~clk_i;

  function automatic int clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int clipv(input int v);
    if (v < 0) return 0;
    if (v > 1300) return 1300;
    return v;
  endfunction

  function automatic out_item_t advance_heater(input in_item_t it);
    out_item_t   r;
    longint      sum4, sum_a, err, mag;
    int          bsum, step, i;
    logic [31:0] since_eval, since_change;
    r = '0;
    r.status = ST_NONE;
    case (it.cmd)
      CMD_SENSOR: begin
        sum4 = longint'(it.probe_a) + longint'(it.probe_b) + longint'(it.probe_c)
               + longint'(it.probe_d);
        avg_now = clip16(sum4 / 4);
        target_now = clip16(longint'(it.ambient_temp) + delta_now);
        if (amb_fill < 4) begin
          amb_hist[amb_fill] = it.ambient_temp;
          amb_fill++;
        end else begin
          since_eval = it.now_ms - eval_ms;
          since_change = it.now_ms - change_ms;
          if (since_eval >= cfg_maintain && since_change >= cfg_holdoff) begin
            eval_ms = it.now_ms;
            sum_a = it.ambient_temp;
            for (i = 0; i < 4; i++) sum_a += amb_hist[i];
            mean_now = clip16(sum_a / 5);
            err = 5 * sum4 - 20 * longint'(delta_now) - 4 * sum_a;
            mag = (err < 0) ? -err : err;
            if (mag <= 160) begin
              r.status = ST_IN_BAND;
            end else begin
              change_ms = it.now_ms;
              if (mag > 960) begin
                r.step_count = 6'd60;
                step = 100;
              end else if (mag > 640) begin
                r.step_count = 6'd35;
                step = 60;
              end else if (mag > 320) begin
                r.step_count = 6'd25;
                step = 40;
              end else begin
                r.step_count = 6'd15;
                step = 20;
              end
              if (volt_now > cfg_knee) step = step * 7 / 10;
              if (err < 0) begin
                if (volt_now >= cfg_vmax) begin
                  r.status = ST_RAISE_REFUSED;
                  r.step_count = '0;
                end else begin
                  volt_now = clipv(volt_now + step);
                  r.status = ST_RAISED;
                end
              end else begin
                if (volt_now <= cfg_vmin) begin
                  r.status = ST_LOWER_REFUSED;
                  r.step_count = '0;
                end else begin
                  volt_now = clipv(volt_now - step);
                  r.status = ST_LOWERED;
                  r.step_dir = 1'b1;
                end
              end
            end
          end
          for (i = 0; i < 3; i++) amb_hist[i] = amb_hist[i + 1];
          amb_hist[3] = it.ambient_temp;
        end
      end
      CMD_BUTTON: begin
        if (btn_fill < 4) begin
          btn_hist[btn_fill] = it.button_level;
          btn_fill++;
        end else begin
          bsum = it.button_level;
          for (i = 0; i < 4; i++) bsum += btn_hist[i];
          if (bsum > 50 && bsum < 70) begin
            delta_now = clip16(longint'(delta_now) + 16);
          end else if (bsum > 90 && bsum < 115) begin
            delta_now = clip16(longint'(delta_now) - 16);
          end
          for (i = 0; i < 3; i++) btn_hist[i] = btn_hist[i + 1];
          btn_hist[3] = it.button_level;
        end
      end
      CMD_SET_DELTA: delta_now = it.set_value;
      default: volt_now = clipv(int'(it.set_value));
    endcase
    r.voltage_tenths = 11'(volt_now);
    r.delta_out = 16'(delta_now);
    r.target_temp = 16'(target_now);
    r.box_average = 16'(avg_now);
    r.ambient_mean = 16'(mean_now);
    return r;
  endfunction

  function automatic in_item_t sensor(input logic [31:0] now, input int a, input int b,
                                      input int c, input int d, input int amb);
    in_item_t it;
    it = '0;
    it.cmd = CMD_SENSOR;
    it.now_ms = now;
    it.probe_a = 16'(a);
    it.probe_b = 16'(b);
    it.probe_c = 16'(c);
    it.probe_d = 16'(d);
    it.ambient_temp = 16'(amb);
    return it;
  endfunction

  function automatic in_item_t knob(input cmd_e c, input int v);
    in_item_t it;
    it = '0;
    it.cmd = c;
    it.button_level = 10'(v);
    it.set_value = 16'(v);
    return it;
  endfunction

  function automatic out_item_t fixed_out(input int volt, input int dl, input int tgt,
                                          input int avg);
    out_item_t r;
    r = '0;
    r.status = ST_NONE;
    r.voltage_tenths = 11'(volt);
    r.delta_out = 16'(dl);
    r.target_temp = 16'(tgt);
    r.box_average = 16'(avg);
    return r;
  endfunction

  task automatic plan(input in_item_t it, input bit pinned, input out_item_t want);
    script_row_t row;
    row.item = it;
    row.pinned = pinned;
    row.want = want;
    script.insert(script.size(), row);
  endtask

  function automatic in_item_t roll_item(input int unsigned stride);
    in_item_t it;
    int       pick, sel, amb, aim;
    it.cmd = cmd_e'(2'($urandom));
    it.now_ms = $urandom;
    it.probe_a = 16'($urandom);
    it.probe_b = 16'($urandom);
    it.probe_c = 16'($urandom);
    it.probe_d = 16'($urandom);
    it.ambient_temp = 16'($urandom);
    it.button_level = 10'($urandom);
    it.set_value = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 62) begin
      it.cmd = CMD_SENSOR;
      sel = $urandom_range(0, 99);
      if (sel < 90) begin
        sim_ms = sim_ms + $urandom_range(0, stride);
        it.now_ms = sim_ms;
      end else if (sel < 95) begin
        it.now_ms = eval_ms - 32'd1;
        sim_ms = it.now_ms;
      end else begin
        sim_ms = it.now_ms;
      end
      if ($urandom_range(0, 9) != 0) begin
        amb = room + int'($urandom_range(0, 60)) - 30;
        aim = clip16(longint'(amb) + delta_now);
        it.ambient_temp = 16'(clip16(amb));
        it.probe_a = 16'(clip16(aim + int'($urandom_range(0, 160)) - 80));
        it.probe_b = 16'(clip16(aim + int'($urandom_range(0, 160)) - 80));
        it.probe_c = 16'(clip16(aim + int'($urandom_range(0, 160)) - 80));
        it.probe_d = 16'(clip16(aim + int'($urandom_range(0, 160)) - 80));
      end
    end else if (pick < 82) begin
      it.cmd = CMD_BUTTON;
      if ($urandom_range(0, 99) < 85) it.button_level = 10'($urandom_range(6, 26));
    end else if (pick < 91) begin
      it.cmd = CMD_SET_DELTA;
      if ($urandom_range(0, 9) < 8) it.set_value = 16'(int'($urandom_range(0, 480)) - 160);
    end else begin
      it.cmd = CMD_SET_VOLT;
      if ($urandom_range(0, 9) < 8) it.set_value = 16'($urandom_range(0, 1300));
    end
    return it;
  endfunction

  task automatic send_item(input in_item_t it, input bit pinned, input out_item_t want);
    int gap, r;
    if (send_mood_left == 0) begin
      send_mood_left = 64;
      send_calm = ($urandom_range(0, 2) == 0);
    end
    send_mood_left--;
    gap = 0;
    r = $urandom_range(0, 99);
    if (!send_calm) begin
      if (r >= 93) gap = $urandom_range(8, 40);
      else if (r >= 60) gap = $urandom_range(1, 3);
    end
    @(negedge clk_i);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= it;
    pin_flag <= pinned;
    pin_want <= want;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic poke_reg(input reg_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_MAINTAIN:   cfg_maintain = val;
      REG_HOLDOFF:    cfg_holdoff = val;
      REG_VOLT_MAX:   cfg_vmax = val[10:0];
      REG_VOLT_MIN:   cfg_vmin = val[10:0];
      REG_VOLT_KNEE:  cfg_knee = val[10:0];
      REG_START_VOLT: volt_now = clipv(int'(val[10:0]));
      default:        delta_now = $signed(val[15:0]);
    endcase
  endtask

  task automatic check_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t %s: expected %0d, actual %0d", $time, field, want, got);
      faults++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    out_item_t want, got;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) begin
        want = advance_heater(in_ch.data);
        due_results.insert(due_results.size(), pin_flag ? pin_want : want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (due_results.size() == 0) begin
          $display("%0t result item with none expected: %p", $time, got);
          faults++;
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, got.status);
          check_field("step_count", want.step_count, got.step_count);
          check_field("step_dir", want.step_dir, got.step_dir);
          check_field("voltage_tenths", want.voltage_tenths, got.voltage_tenths);
          check_field("delta_out", want.delta_out, got.delta_out);
          check_field("target_temp", want.target_temp, got.target_temp);
          check_field("box_average", want.box_average, got.box_average);
          check_field("ambient_mean", want.ambient_mean, got.ambient_mean);
        end
      end
    end
  end

  initial begin : drain_side
    int gap, mood_left, idle_pct;
    out_ch.ready = 1'b0;
    gap = 0;
    mood_left = 0;
    idle_pct = 0;
    forever begin
      @(negedge clk_i);
      if (choke_req) begin
        choke_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end
      if (mood_left == 0) begin
        mood_left = $urandom_range(50, 200);
        idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 50);
      end
      mood_left--;
      if (gap > 0) begin
        gap--;
        out_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < idle_pct) begin
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    int          ph, n;
    int unsigned stride;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    faults = 0;
    pin_flag = 1'b0;
    pin_want = '0;
    choke_req = 1'b0;
    send_mood_left = 0;
    send_calm = 1'b0;
    sim_ms = '0;
    cfg_maintain = MAINTAIN_RST;
    cfg_holdoff = HOLDOFF_RST;
    cfg_vmax = VOLT_MAX_RST;
    cfg_vmin = VOLT_MIN_RST;
    cfg_knee = VOLT_KNEE_RST;
    amb_hist = '{default: 0};
    btn_hist = '{default: 0};
    amb_fill = 0;
    btn_fill = 0;
    delta_now = START_DELTA_RST;
    volt_now = START_VOLT_RST;
    mean_now = 0;
    avg_now = 0;
    target_now = 0;
    eval_ms = '0;
    change_ms = '0;

    plan(sensor(0, 32767, 32767, 32767, 32767, 32767), 1'b1,
         fixed_out(540, 160, 32767, 32767));
    plan(sensor(1000, -32768, -32768, -32768, -32768, -32768), 1'b1,
         fixed_out(540, 160, -32608, -32768));
    plan(knob(CMD_BUTTON, 1023), 1'b1, fixed_out(540, 160, -32608, -32768));
    plan(knob(CMD_BUTTON, 0), 1'b1, fixed_out(540, 160, -32608, -32768));
    plan(knob(CMD_SET_DELTA, 32767), 1'b1, fixed_out(540, 32767, -32608, -32768));
    plan(knob(CMD_SET_DELTA, -32768), 1'b1, fixed_out(540, -32768, -32608, -32768));
    plan(knob(CMD_SET_VOLT, -1), 1'b1, fixed_out(0, -32768, -32608, -32768));
    plan(knob(CMD_SET_VOLT, 32767), 1'b1, fixed_out(1300, -32768, -32608, -32768));
    plan(knob(CMD_SET_VOLT, 540), 1'b1, fixed_out(540, -32768, -32608, -32768));
    plan(knob(CMD_SET_DELTA, 160), 1'b1, fixed_out(540, 160, -32608, -32768));
    plan(sensor(2000, 1, 1, 1, 0, 0), 1'b1, fixed_out(540, 160, 160, 0));
    plan(sensor(3000, -1, -1, -1, 0, 0), 1'b1, fixed_out(540, 160, 160, 0));
    plan(sensor(120000, 0, 0, 0, 0, 0), 1'b0, '0);
    plan(sensor(240000, 0, 0, 0, 0, 0), 1'b0, '0);
    plan(sensor(360000, 168, 168, 168, 168, 0), 1'b0, '0);
    plan(sensor(420000, 152, 152, 152, 152, 0), 1'b0, '0);
    plan(sensor(480000, 169, 169, 169, 169, 0), 1'b0, '0);
    plan(sensor(600000, 200, 200, 200, 200, 0), 1'b0, '0);
    plan(sensor(720000, 220, 220, 220, 220, 0), 1'b0, '0);
    plan(sensor(840000, 190, 190, 190, 190, 0), 1'b0, '0);
    plan(knob(CMD_SET_VOLT, 1150), 1'b0, '0);
    plan(sensor(960000, 0, 0, 0, 0, 0), 1'b0, '0);
    plan(knob(CMD_SET_VOLT, 100), 1'b0, '0);
    plan(sensor(1080000, 200, 200, 200, 200, 0), 1'b0, '0);
    plan(knob(CMD_SET_VOLT, 900), 1'b0, '0);
    plan(sensor(1200000, 0, 0, 0, 0, 0), 1'b0, '0);

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[i]) send_item(script[i].item, script[i].pinned, script[i].want);
    settle();
    sim_ms = 32'd1200000;

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          poke_reg(REG_MAINTAIN, 32'd0);
          poke_reg(REG_HOLDOFF, 32'd0);
          poke_reg(REG_VOLT_MAX, 32'd1300);
          poke_reg(REG_VOLT_MIN, 32'd0);
          poke_reg(REG_VOLT_KNEE, 32'd0);
          poke_reg(REG_START_VOLT, 32'd0);
          poke_reg(REG_START_DELTA, 32'h0000_7FFF);
          stride = 100;
        end
        1: begin
          poke_reg(REG_MAINTAIN, 32'hFFFF_FFFF);
          poke_reg(REG_HOLDOFF, 32'hFFFF_FFFF);
          poke_reg(REG_VOLT_MAX, 32'd0);
          poke_reg(REG_VOLT_MIN, 32'd1300);
          poke_reg(REG_VOLT_KNEE, 32'd1300);
          poke_reg(REG_START_VOLT, 32'd1300);
          poke_reg(REG_START_DELTA, 32'hFFFF_8000);
          stride = 32'h8000_0000;
        end
        2: begin
          poke_reg(REG_MAINTAIN, MAINTAIN_RST);
          poke_reg(REG_HOLDOFF, HOLDOFF_RST);
          poke_reg(REG_VOLT_MAX, 32'(VOLT_MAX_RST));
          poke_reg(REG_VOLT_MIN, 32'(VOLT_MIN_RST));
          poke_reg(REG_VOLT_KNEE, 32'(VOLT_KNEE_RST));
          poke_reg(REG_START_VOLT, 32'(START_VOLT_RST));
          poke_reg(REG_START_DELTA, 32'(START_DELTA_RST));
          stride = 150000;
        end
        default: begin
          poke_reg(REG_MAINTAIN, $urandom_range(0, 5000));
          poke_reg(REG_HOLDOFF, $urandom_range(0, 5000));
          poke_reg(REG_VOLT_MAX, $urandom_range(600, 1300));
          poke_reg(REG_VOLT_MIN, $urandom_range(0, 600));
          poke_reg(REG_VOLT_KNEE, $urandom_range(0, 1300));
          poke_reg(REG_START_VOLT, $urandom_range(0, 1300));
          poke_reg(REG_START_DELTA, 32'(int'($urandom_range(0, 640)) - 320));
          stride = 8000;
        end
      endcase
      room = int'($urandom_range(0, 3200)) - 1600;
      for (n = 0; n < 325; n++) begin
        if (ph == 3 && n == 40) choke_req = 1'b1;
        send_item(roll_item(stride), 1'b0, '0);
      end
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (faults == 0 && due_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
